// ===== rtl/lzssd_pkg.sv =====
package lzssd_pkg;

	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam int MIN_LEN = 3;
	localparam int MAX_LEN = 18;
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = $clog2(MAX_LEN);

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} win_ctl_t;

	typedef enum logic [1:0] {
		PH_BOUND = 2'd0,
		PH_ITEM  = 2'd1,
		PH_PAIR  = 2'd2
	} phase_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LIT  = 5'b00010,
		S_RD   = 5'b00100,
		S_EMIT = 5'b01000,
		S_WR   = 5'b10000
	} state_t;

endpackage

// ===== rtl/lzssd_window.sv =====
module lzssd_window #(
	parameter int WINDOW_DEPTH = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lzssd_pkg::win_ctl_t         ctl,
	input  logic [7:0]                  wr_data,
	input  logic [$clog2(WINDOW_DEPTH)-1:0] rd_addr,
	output logic [7:0]                  rd_data
);
	import lzssd_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);

	// Entries are written strictly in order from address zero, so an entry
	// below the write position, or any entry once the window has wrapped,
	// holds written data; every other entry still reads as a space.
	logic [7:0]    mem [WINDOW_DEPTH];
	logic [AW-1:0] wpos_q;
	logic          full_q;
	logic          hit_q;
	logic [7:0]    rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			full_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				wpos_q <= wpos_q + AW'(1);
				if (wpos_q == AW'(WINDOW_DEPTH - 1)) begin
					full_q <= 1'b1;
				end
			end
			if (ctl.rd_en) begin
				hit_q <= full_q || (rd_addr < wpos_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wpos_q] <= wr_data;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rd_data = hit_q ? rdata_q : SPACE_BYTE;

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q)
		else $error("window fill flag cleared");

endmodule

// ===== rtl/lzss_stream_decoder_top.sv =====
// LZSS stream decoder with a 4096-byte window that starts filled with spaces.
// Compressed bytes enter one per transfer on the input channel; decoded bytes
// leave one per transfer on the output channel, with last_of_run marking the
// final byte that one input byte produces. A flag byte or the first byte of a
// pair is only taken in, a literal is passed to the output register, and a
// pair of length L (3 to 18) is copied: the window is read and written in
// separate states, with a registered read, so every copied byte is first read
// out and emitted, and then the run is written back at the write position.
// Input is stalled while a byte is being worked on; a decoded byte waiting in
// the output register does not hold off the next input transfer.
module lzss_stream_decoder_top #(
	parameter int WINDOW_DEPTH = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] code_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);
	import lzssd_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);

	state_t             state_q;
	phase_t             phase_q;
	logic [7:0]         flag_q;
	logic [3:0]         fcnt_q;
	logic [7:0]         ofs_hi_q;
	logic [AW-1:0]      ofs_q;
	logic [LEN_W-1:0]   len_q;
	logic [IDX_W-1:0]   idx_q;
	logic [7:0]         lit_q;
	logic [7:0]         copy_q [MAX_LEN];
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               last_q;

	logic               in_acc;
	logic               out_free;
	logic               out_load;
	logic [7:0]         flag_shift;
	logic [3:0]         fcnt_nx;
	logic               item_now;
	logic               bit_cur;
	logic               acc_pair2;
	logic               acc_flag;
	logic               acc_lit;
	logic               acc_first;
	logic               last_now;
	logic [11:0]        ofs_full;
	win_ctl_t           win_ctl;
	logic [7:0]         win_wdata;
	logic [AW-1:0]      win_raddr;
	logic [7:0]         win_rdata;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		flag_shift = {1'b0, flag_q[7:1]};
		fcnt_nx    = fcnt_q + 4'd1;
		item_now   = (phase_q == PH_ITEM) || (fcnt_nx < 4'd8);
		bit_cur    = (phase_q == PH_ITEM) ? flag_q[0] : flag_shift[0];
		acc_pair2  = in_acc && (phase_q == PH_PAIR);
		acc_flag   = in_acc && (phase_q != PH_PAIR) && !item_now;
		acc_lit    = in_acc && (phase_q != PH_PAIR) && item_now && bit_cur;
		acc_first  = in_acc && (phase_q != PH_PAIR) && item_now && !bit_cur;
		last_now   = (LEN_W'(idx_q) + LEN_W'(1)) == len_q;
		ofs_full   = {ofs_hi_q, code_byte[7:4]};
		out_load   = out_free && ((state_q == S_LIT) || (state_q == S_EMIT));
	end

	always_comb begin
		win_ctl.wr_en = acc_lit || (state_q == S_WR);
		win_ctl.rd_en = (state_q == S_RD);
		win_wdata     = (state_q == S_WR) ? copy_q[idx_q] : code_byte;
		win_raddr     = ofs_q + AW'(idx_q);
	end

	lzssd_window #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (win_ctl),
		.wr_data (win_wdata),
		.rd_addr (win_raddr),
		.rd_data (win_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_BOUND;
			flag_q      <= '0;
			fcnt_q      <= 4'd7;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_pair2) begin
						idx_q   <= '0;
						phase_q <= PH_BOUND;
						state_q <= S_RD;
					end else if (acc_flag) begin
						flag_q  <= code_byte;
						fcnt_q  <= 4'd0;
						phase_q <= PH_ITEM;
					end else if (acc_lit || acc_first) begin
						if (phase_q != PH_ITEM) begin
							flag_q <= flag_shift;
							fcnt_q <= fcnt_nx;
						end
						if (acc_lit) begin
							phase_q <= PH_BOUND;
							state_q <= S_LIT;
						end else begin
							phase_q <= PH_PAIR;
						end
					end
				end
				S_LIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (last_now) begin
							idx_q   <= '0;
							state_q <= S_WR;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_RD;
						end
					end
				end
				S_WR: begin
					if (last_now) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_first) begin
			ofs_hi_q <= code_byte;
		end
		if (acc_pair2) begin
			ofs_q <= ofs_full[AW-1:0];
			len_q <= LEN_W'(code_byte[3:0]) + LEN_W'(MIN_LEN);
		end
		if (acc_lit) begin
			lit_q <= code_byte;
		end
		if ((state_q == S_LIT) && out_free) begin
			out_byte_q <= lit_q;
			last_q     <= 1'b1;
		end
		if ((state_q == S_EMIT) && out_free) begin
			out_byte_q     <= win_rdata;
			last_q         <= last_now;
			copy_q[idx_q]  <= win_rdata;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_EMIT || state_q == S_WR)
		|-> (LEN_W'(idx_q) < len_q))
		else $error("copy index beyond run length");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_EMIT || state_q == S_WR)
		|-> (len_q >= LEN_W'(MIN_LEN) && len_q <= LEN_W'(MAX_LEN)))
		else $error("run length out of range");

	a_flag_count: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= 4'd8)
		else $error("flag bit count out of range");

	a_emit_then_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free && last_now) |=> (state_q == S_WR && idx_q == '0))
		else $error("copy write-back did not start at the first byte");

endmodule

// ===== dv/lzss_decode_checker.sv =====
`timescale 1ns / 1ps

module lzss_decode_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] code_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       last_of_run,
	output int         fail_count,
	output int         pending
);
	import lzssd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} plain_byte_t;

	logic [7:0]  history [4096];
	logic [11:0] put_pos;
	logic [7:0]  flag_reg;
	logic [3:0]  flags_used;
	phase_t      stage;
	logic [7:0]  offset_hi;
	plain_byte_t plain_q [$];
	plain_byte_t want;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic store_byte(input logic [7:0] b);
		history[put_pos] = b;
		put_pos++;
	endtask

	task automatic start_item(input logic [7:0] b);
		if (flag_reg[0]) begin
			store_byte(b);
			plain_q.push_back('{data: b, last: 1'b1});
			stage = PH_BOUND;
		end else begin
			offset_hi = b;
			stage = PH_PAIR;
		end
	endtask

	// All bytes of a copy are read before any is written back, so a copy that
	// overlaps its destination repeats the old window contents.
	task automatic decode_byte(input logic [7:0] b);
		logic [11:0] src;
		int          run_len;
		logic [7:0]  copied [MAX_LEN];
		case (stage)
			PH_PAIR: begin
				src = {offset_hi, b[7:4]};
				run_len = int'(b[3:0]) + MIN_LEN;
				for (int i = 0; i < run_len; i++) begin
					copied[i] = history[src + 12'(i)];
					plain_q.push_back('{data: copied[i], last: (i == run_len - 1)});
				end
				for (int i = 0; i < run_len; i++) begin
					store_byte(copied[i]);
				end
				stage = PH_BOUND;
			end
			PH_ITEM: begin
				start_item(b);
			end
			default: begin
				flag_reg = flag_reg >> 1;
				flags_used = flags_used + 4'd1;
				if (flags_used >= 4'd8) begin
					flag_reg = b;
					flags_used = '0;
					stage = PH_ITEM;
				end else begin
					start_item(b);
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4096; i++) begin
				history[i] = SPACE_BYTE;
			end
			put_pos = '0;
			flag_reg = '0;
			flags_used = 4'd7;
			stage = PH_BOUND;
			offset_hi = '0;
			plain_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (plain_q.size() == 0) begin
					report_mismatch($sformatf("unexpected output byte %02h", out_byte));
				end else begin
					want = plain_q.pop_front();
					if (out_byte !== want.data) begin
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, want.data));
					end
					if (last_of_run !== want.last) begin
						report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
							last_of_run, want.last, want.data));
					end
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(code_byte);
			end
			pending <= plain_q.size();
		end
	end

endmodule

// ===== dv/tb_lzss_stream_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_lzss_stream_decoder_top;
	import lzssd_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] code_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       last_of_run;
	int         fail_count;
	int         pending;

	logic       hold_req;
	int         idle_pct;
	int         n_sent;
	int         n_out;
	int         n_lits;
	int         n_pairs;

	lzss_stream_decoder_top DUT (.*);

	lzss_decode_checker watch (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles with %0d bytes outstanding", cycles, pending);
		$display("FAIL lzss_stream_decoder_top");
		$finish;
	end

	initial begin
		logic hold_done;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= (idle_pct != 0 && $urandom_range(99) < idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			code_byte <= 8'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
	endtask

	task automatic send_literal(input logic [7:0] b);
		send_byte(b);
		n_lits++;
		n_out++;
	endtask

	task automatic send_pair(input logic [11:0] src, input logic [3:0] len_code);
		send_byte(src[11:4]);
		send_byte({src[3:0], len_code});
		n_pairs++;
		n_out += int'(len_code) + MIN_LEN;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Most groups are copies, many of them at full length and close behind the
	// write position, so that copies often overlap the bytes they produce.
	task automatic send_random_group();
		logic [7:0]  flags;
		logic [11:0] src;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			flags = 8'h00;
		end else if (pick < 25) begin
			flags = 8'hFF;
		end else begin
			flags = 8'($urandom & $urandom);
		end
		send_byte(flags);
		for (int i = 0; i < 8; i++) begin
			if (flags[i]) begin
				send_literal(8'($urandom));
			end else begin
				src = $urandom_range(1) ? 12'(n_out - $urandom_range(1, 20)) : 12'($urandom);
				send_pair(src, ($urandom_range(99) < 75) ? 4'hF : 4'($urandom));
			end
		end
	endtask

	initial begin
		int grp;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		code_byte <= '0;
		hold_req <= 1'b0;
		idle_pct <= 6;
		n_sent = 0;
		n_out = 0;
		n_lits = 0;
		n_pairs = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h93);
		send_literal(8'h00);
		send_literal(8'hFF);
		send_pair(12'h000, 4'h0);
		send_pair(12'(n_out - 1), 4'hF);
		send_literal(8'h5A);
		send_pair(12'hFFF, 4'hF);
		send_pair(12'(n_out - 3), 4'h7);
		send_literal(8'hA5);
		send_byte(8'hFF);
		for (int i = 0; i < 8; i++) begin
			send_literal(8'(1 << i));
		end

		grp = 0;
		while (n_sent < 300) begin
			if (grp == 3) begin
				hold_req <= 1'b1;
			end
			if (grp == 6) begin
				idle_pct <= 0;
			end
			if (grp == 11) begin
				idle_pct <= 6;
			end
			if (grp == 14) begin
				wait_drained();
			end
			send_random_group();
			grp++;
		end

		// The stream ends inside a copy, which must produce nothing further.
		send_byte(8'h00);
		send_byte(8'h7C);
		wait_drained();
		repeat (60) @(posedge clk);

		$display("Sent %0d code bytes: %0d literals and %0d copies, %0d decoded bytes.",
			n_sent, n_lits, n_pairs, n_out);
		$display("Copies overlapping their output and wrapping past the window end, %0s; %0d mismatches.",
			"a long output hold and a full drain", fail_count);
		if (fail_count == 0) begin
			$display("PASS lzss_stream_decoder_top");
		end else begin
			$display("FAIL lzss_stream_decoder_top");
		end
		$finish;
	end

endmodule
